@@ hdl/qea_pkg.sv @@
// ----------------------------------------------------------------------------
// qea_pkg
// Shared types and constants for the quadrature encoder bank decoder.
// ----------------------------------------------------------------------------
package qea_pkg;

    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_LIMIT = 2'd2;

    localparam logic        ACCEL_ENABLE_RST = 1'b1;
    localparam logic [19:0] FAST_LIMIT_RST   = 20'd1000;
    localparam logic [19:0] MEDIUM_LIMIT_RST = 20'd5000;

    // {previous code, new code} transitions
    localparam logic [3:0] TR_CW_A  = 4'b1101;
    localparam logic [3:0] TR_CW_B  = 4'b0100;
    localparam logic [3:0] TR_CW_C  = 4'b0010;
    localparam logic [3:0] TR_CW_D  = 4'b1011;
    localparam logic [3:0] TR_CCW_A = 4'b1110;
    localparam logic [3:0] TR_CCW_B = 4'b0111;
    localparam logic [3:0] TR_CCW_C = 4'b0001;
    localparam logic [3:0] TR_CCW_D = 4'b1000;

    // full-speed step size: threshold is FULL_STEP >> accel shift
    localparam logic [2:0] FULL_STEP = 3'd4;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_CW,
        DIR_CCW
    } dir_t;

    typedef struct packed {
        logic              accel_enable;
        logic [LIMIT_W-1:0] fast_limit_us;
        logic [LIMIT_W-1:0] medium_limit_us;
    } cfg_t;

    // one channel's stored state
    typedef struct packed {
        logic [1:0]        prev_code;
        logic signed [2:0] step_accum;
        logic [TIME_W-1:0] last_step_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic dir_t direction_of(input logic [3:0] transition);
        dir_t dir;
        unique case (transition)
            TR_CW_A, TR_CW_B, TR_CW_C, TR_CW_D:     dir = DIR_CW;
            TR_CCW_A, TR_CCW_B, TR_CCW_C, TR_CCW_D: dir = DIR_CCW;
            default:                                dir = DIR_NONE;
        endcase
        return dir;
    endfunction

endpackage

@@ hdl/qea_sample_if.sv @@
// ----------------------------------------------------------------------------
// qea_sample_if
// Valid/ready channel carrying one sampled encoder pin pair with timestamp.
// ----------------------------------------------------------------------------
interface qea_sample_if;
    logic        valid;
    logic        ready;
    logic        bank;
    logic [3:0]  encoder;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] time_us;

    modport source (output valid, bank, encoder, pin_a, pin_b, time_us, input ready);
    modport sink   (input valid, bank, encoder, pin_a, pin_b, time_us, output ready);
endinterface

@@ hdl/qea_step_if.sv @@
// ----------------------------------------------------------------------------
// qea_step_if
// Valid/ready channel carrying one emitted detent step.
// ----------------------------------------------------------------------------
interface qea_step_if;
    logic              valid;
    logic              ready;
    logic              out_bank;
    logic [3:0]        out_encoder;
    logic signed [3:0] step_amount;

    modport source (output valid, out_bank, out_encoder, step_amount, input ready);
    modport sink   (input valid, out_bank, out_encoder, step_amount, output ready);
endinterface

@@ hdl/qea_ram.sv @@
// ----------------------------------------------------------------------------
// qea_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/qea_update.sv @@
// ----------------------------------------------------------------------------
// qea_update
// Per-channel transition decode, acceleration pick and accumulator update.
// ----------------------------------------------------------------------------
module qea_update (
    input  qea_pkg::cfg_t        cfg,
    input  qea_pkg::entry_t      cur,
    input  logic [1:0]           code,
    input  logic [31:0]          time_us,
    output qea_pkg::entry_t      nxt,
    output logic                 emit,
    output logic signed [3:0]    step_amount
);
    import qea_pkg::*;

    dir_t              dir;
    logic [TIME_W-1:0] interval;
    logic              is_fast;
    logic              is_medium;
    logic [1:0]        accel_shift;
    logic signed [3:0] sum;
    logic [3:0]        mag;
    logic [2:0]        thr;
    logic [3:0]        accel;

    assign dir      = direction_of({cur.prev_code, code});
    assign interval = time_us - cur.last_step_time;   // wraps mod 2^32
    assign is_fast   = interval < {{(TIME_W-LIMIT_W){1'b0}}, cfg.fast_limit_us};
    assign is_medium = interval < {{(TIME_W-LIMIT_W){1'b0}}, cfg.medium_limit_us};

    always_comb
    begin
        priority if (!cfg.accel_enable)
            accel_shift = 2'd0;
        else if (is_fast)
            accel_shift = 2'd2;
        else if (is_medium)
            accel_shift = 2'd1;
        else
            accel_shift = 2'd0;
    end

    assign sum   = {cur.step_accum[2], cur.step_accum}
                 + ((dir == DIR_CCW) ? 4'sb1111 : 4'sb0001);
    assign mag   = sum[3] ? 4'(-sum) : 4'(sum);
    assign thr   = FULL_STEP >> accel_shift;
    assign accel = 4'b0001 << accel_shift;

    always_comb
    begin
        nxt           = cur;
        nxt.prev_code = code;
        emit          = 1'b0;
        if (dir != DIR_NONE)
        begin
            nxt.last_step_time = time_us;
            if (mag >= {1'b0, thr})
            begin
                emit           = 1'b1;
                nxt.step_accum = 3'sd0;
            end
            else
            begin
                nxt.step_accum = sum[2:0];
            end
        end
    end

    assign step_amount = sum[3] ? 4'(-accel) : accel;

endmodule

@@ hdl/quadrature_encoder_accel_bank.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_accel_bank
// Quadrature decoder for BANKS x ENCODERS_PER_BANK rotary encoders with
// speed-dependent step acceleration.
// ----------------------------------------------------------------------------
// Takes one pin sample beat per clock unless the output stalls and presents
// at most one step beat for it via stage 1 and the out register. Per-channel
// state (last code, step accumulator, last step time) sits in a single RAM
// with a registered read; a one-entry write bypass covers back-to-back
// samples of the same channel. After reset the RAM is zeroed by a clearing
// pass over all BANKS*ENCODERS_PER_BANK entries, during which no sample is
// accepted (register writes are taken at any time). Samples for a channel
// outside the configured bank/encoder range are dropped without effect.
module quadrature_encoder_accel_bank #(
    parameter int ENCODERS_PER_BANK = 16,
    parameter int BANKS             = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qea_sample_if.sink                        samples,
    qea_step_if.source                        steps,
    input  logic                              wr_en,
    input  logic [qea_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [qea_pkg::CFG_DATA_W-1:0]    wr_data
);
    import qea_pkg::*;

    localparam int CHANNELS = BANKS * ENCODERS_PER_BANK;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_enable    <= ACCEL_ENABLE_RST;
            cfg_reg.fast_limit_us   <= FAST_LIMIT_RST;
            cfg_reg.medium_limit_us <= MEDIUM_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ACCEL_ENABLE: cfg_reg.accel_enable    <= wr_data[0];
                REG_FAST_LIMIT:   cfg_reg.fast_limit_us   <= wr_data[LIMIT_W-1:0];
                REG_MEDIUM_LIMIT: cfg_reg.medium_limit_us <= wr_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // clearing pass
    logic            clear_active_reg;
    logic [CH_W-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == CH_W'(CHANNELS - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // stage 1 registers and handshake
    logic            s1_valid_reg;
    logic            s1_in_range_reg;
    logic [CH_W-1:0] s1_ch_reg;
    logic            s1_bank_reg;
    logic [3:0]      s1_encoder_reg;
    logic [1:0]      s1_code_reg;
    logic [31:0]     s1_time_reg;

    logic            out_valid_reg;
    logic            out_bank_reg;
    logic [3:0]      out_encoder_reg;
    logic signed [3:0] out_step_reg;

    logic            s1_advance;
    logic            accept;
    logic            in_range;
    logic [CH_W-1:0] in_ch;

    assign s1_advance    = !out_valid_reg || steps.ready;
    assign samples.ready = !clear_active_reg && (!s1_valid_reg || s1_advance);
    assign accept        = samples.valid && samples.ready;

    assign in_range = (32'(samples.bank) < 32'(BANKS))
                   && (32'(samples.encoder) < 32'(ENCODERS_PER_BANK));
    assign in_ch    = CH_W'(32'(samples.bank) * 32'(ENCODERS_PER_BANK)
                          + 32'(samples.encoder));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_range_reg <= in_range;
            s1_ch_reg       <= in_ch;
            s1_bank_reg     <= samples.bank;
            s1_encoder_reg  <= samples.encoder;
            s1_code_reg     <= {samples.pin_a, samples.pin_b};
            s1_time_reg     <= samples.time_us;
        end
    end

    // state RAM with write bypass
    logic            ram_we;
    logic [CH_W-1:0] ram_waddr;
    entry_t          ram_wdata;
    logic [CH_W-1:0] ram_raddr;
    entry_t          ram_rdata;
    logic            item_we;

    logic            byp_valid_reg;
    logic [CH_W-1:0] byp_addr_reg;
    entry_t          byp_data_reg;

    entry_t          cur_entry;
    entry_t          nxt_entry;
    logic            emit;
    logic signed [3:0] step_amount;

    assign item_we   = s1_valid_reg && s1_in_range_reg && s1_advance;
    assign ram_we    = clear_active_reg || item_we;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : s1_ch_reg;
    assign ram_wdata = clear_active_reg ? '0 : nxt_entry;
    assign ram_raddr = accept ? in_ch : s1_ch_reg;

    qea_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS),
        .ADDR_W(CH_W)
    ) u_state_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (item_we)
        begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            byp_addr_reg <= s1_ch_reg;
            byp_data_reg <= nxt_entry;
        end
    end

    // the RAM read may have raced the previous beat's write
    assign cur_entry = (byp_valid_reg && byp_addr_reg == s1_ch_reg) ? byp_data_reg
                                                                    : ram_rdata;

    qea_update u_update (
        .cfg        (cfg_reg),
        .cur        (cur_entry),
        .code       (s1_code_reg),
        .time_us    (s1_time_reg),
        .nxt        (nxt_entry),
        .emit       (emit),
        .step_amount(step_amount)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg && s1_in_range_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_bank_reg    <= s1_bank_reg;
            out_encoder_reg <= s1_encoder_reg;
            out_step_reg    <= step_amount;
        end
    end

    assign steps.valid       = out_valid_reg;
    assign steps.out_bank    = out_bank_reg;
    assign steps.out_encoder = out_encoder_reg;
    assign steps.step_amount = out_step_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !accept
    ) else $error("sample accepted during RAM clearing pass");

    a_step_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_step_reg == 4'sd1 || out_step_reg == -4'sd1
                        || out_step_reg == 4'sd2 || out_step_reg == -4'sd2
                        || out_step_reg == 4'sd4 || out_step_reg == -4'sd4)
    ) else $error("illegal step amount");

    a_result_from_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_in_range_reg)
    ) else $error("result without an in-range stage item");

    a_bypass_tracks_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_we |=> (byp_valid_reg && byp_addr_reg == $past(s1_ch_reg))
    ) else $error("bypass register missed a state write");

    a_stall_holds_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !steps.ready) |=> (out_valid_reg && $stable(out_step_reg))
    ) else $error("pending result changed while stalled");
`endif

endmodule
